/* sv/scbpa_pkg.sv */
// scbpa_pkg: shared widths, codes, command and state types of the pool allocator
// no dependencies; imported by every other file of the block except scbpa_ram
package scbpa_pkg;

   localparam int ADDR_W        = 48;
   localparam int SIZE_W        = 16;
   localparam int ALOG_W        = 4;
   localparam int STATUS_W      = 2;
   localparam int POOL_IDX_W    = 3;
   localparam int SLOT_IDX_W    = 10;
   localparam int CSR_IDX_W     = 4;
   localparam int CFG_REGS      = 8;
   localparam int CLS_W         = 4;
   localparam int MIN_SLOT_LOG2 = 3;

   typedef enum logic {
      FUNC_ALLOC = 1'b0,
      FUNC_FREE  = 1'b1
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      STAT_OK          = 2'd0,
      STAT_EXHAUSTED   = 2'd1,
      STAT_TOO_LARGE   = 2'd2,
      STAT_OUT_OF_POOL = 2'd3
   } status_type;

   // classified request as it travels from front to back
   typedef struct packed {
      func_type           func;
      logic [CLS_W-1:0]   cls;
      logic               too_large;
      logic [ALOG_W-1:0]  align_log2;
      logic [ADDR_W-1:0]  base;
      logic [ADDR_W-1:0]  diff;
      logic               borrow;
   } cmd_type;

   typedef enum logic [3:0] {
      B_CLEAR,
      B_IDLE,
      B_DECODE,
      B_SCAN,
      B_ALLOC_WR,
      B_ADDR,
      B_ALIGN,
      B_DIV_MUL,
      B_DIV_QUO,
      B_DIV_REM,
      B_FREE_WR,
      B_EMIT
   } back_state_type;

endpackage

/* sv/scbpa_ifs.sv */
// scbpa_ifs: request, response and register-write channel interfaces
// depends on scbpa_pkg for field widths
interface scbpa_req_if;
   import scbpa_pkg::*;
   logic                valid;
   logic                ready;
   logic                func;
   logic [SIZE_W-1:0]   req_size;
   logic [ALOG_W-1:0]   align_log2;
   logic [ADDR_W-1:0]   free_addr;
   modport source (output valid, func, req_size, align_log2, free_addr, input ready);
   modport sink   (input valid, func, req_size, align_log2, free_addr, output ready);
endinterface

interface scbpa_rsp_if;
   import scbpa_pkg::*;
   logic                  valid;
   logic                  ready;
   logic [ADDR_W-1:0]     addr;
   logic [STATUS_W-1:0]   status;
   logic [POOL_IDX_W-1:0] pool_index;
   logic [SLOT_IDX_W-1:0] slot_index;
   modport source (output valid, addr, status, pool_index, slot_index, input ready);
   modport sink   (input valid, addr, status, pool_index, slot_index, output ready);
endinterface

interface scbpa_csr_if;
   import scbpa_pkg::*;
   logic                 valid;
   logic                 ready;
   logic [CSR_IDX_W-1:0] index;
   logic [ADDR_W-1:0]    data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface

/* sv/scbpa_ram.sv */
// scbpa_ram: generic single-write, single-read RAM with registered read data
// no dependencies
module scbpa_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 128
) (
   input  logic                                      clock,
   input  logic                                      we,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                          wdata,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                          rdata
);
   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/scbpa_front.sv */
// scbpa_front: pool base registers, size-class decode and base offset of each request
// depends on scbpa_pkg and scbpa_ifs
module scbpa_front #(
   parameter int POOL_COUNT = 8
) (
   input  logic              clock,
   input  logic              reset,
   scbpa_req_if.sink         req,
   scbpa_csr_if.sink         csr,
   input  logic              clearing,
   output logic              push_valid,
   input  logic              push_ready,
   output scbpa_pkg::cmd_type push_data
);
   import scbpa_pkg::*;

   localparam int PW = (POOL_COUNT > 1) ? $clog2(POOL_COUNT) : 1;

   logic [ADDR_W-1:0] pool_base_ff [POOL_COUNT];
   logic [ADDR_W-1:0] pool_base_in [POOL_COUNT];
   logic [CLS_W-1:0]  msb_pos;
   logic [CLS_W-1:0]  lg;
   logic [CLS_W-1:0]  cls;
   logic              too_large;
   logic [ADDR_W-1:0] base_sel;
   logic [ADDR_W:0]   diff_wide;
   logic              cfg_hit;

   // highest set bit of the size, zero size lands in the smallest class
   always_comb begin
      msb_pos = '0;
      for (int i = 0; i < SIZE_W; i++) begin
         if (req.req_size[i]) begin
            msb_pos = CLS_W'(i);
         end
      end
      lg        = (msb_pos < CLS_W'(MIN_SLOT_LOG2)) ? CLS_W'(MIN_SLOT_LOG2) : msb_pos;
      cls       = lg - CLS_W'(MIN_SLOT_LOG2);
      too_large = ({1'b0, cls} >= (CLS_W + 1)'(POOL_COUNT));
      base_sel  = too_large ? '0 : pool_base_ff[cls[PW-1:0]];
      diff_wide = {1'b0, req.free_addr} - {1'b0, base_sel};
   end

   always_comb begin
      push_data.func       = func_type'(req.func);
      push_data.cls        = cls;
      push_data.too_large  = too_large;
      push_data.align_log2 = req.align_log2;
      push_data.base       = base_sel;
      push_data.diff       = diff_wide[ADDR_W-1:0];
      push_data.borrow     = diff_wide[ADDR_W];
   end

   assign push_valid = req.valid && !clearing;
   assign req.ready  = push_ready && !clearing;
   assign csr.ready  = 1'b1;

   assign cfg_hit = csr.valid && (32'(csr.index) < CFG_REGS) && (32'(csr.index) < POOL_COUNT);

   always_comb begin
      for (int p = 0; p < POOL_COUNT; p++) begin
         pool_base_in[p] = pool_base_ff[p];
      end
      if (cfg_hit) begin
         pool_base_in[csr.index[PW-1:0]] = csr.data;
      end
   end

   always_ff @(posedge clock) begin
      for (int p = 0; p < POOL_COUNT; p++) begin
         if (reset) begin
            pool_base_ff[p] <= '0;
         end else begin
            pool_base_ff[p] <= pool_base_in[p];
         end
      end
   end
endmodule

/* sv/scbpa_cmd_queue.sv */
// scbpa_cmd_queue: two-entry queue of classified requests between front and back
// depends on scbpa_pkg
module scbpa_cmd_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push_valid,
   output logic               push_ready,
   input  scbpa_pkg::cmd_type push_data,
   output logic               pop_valid,
   input  logic               pop_ready,
   output scbpa_pkg::cmd_type pop_data
);
   import scbpa_pkg::*;

   localparam int QUEUE_DEPTH = 2;
   localparam int PTR_W       = $clog2(QUEUE_DEPTH);
   localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

   cmd_type          entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push, do_pop;

   assign push_ready = (count_ff != CNT_W'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_data   = entry_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end
endmodule

/* sv/scbpa_back.sv */
// scbpa_back: free-bitmap sequencer (clearing pass, word scan, free update), address computation and result register
// depends on scbpa_pkg, scbpa_ifs and scbpa_ram
module scbpa_back #(
   parameter int SLOTS_PER_POOL = 1024,
   parameter int POOL_COUNT     = 8,
   parameter int MAP_WORD_BITS  = 64
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               pop_valid,
   output logic               pop_ready,
   input  scbpa_pkg::cmd_type pop_data,
   output logic               clearing,
   scbpa_rsp_if.source        rsp
);
   import scbpa_pkg::*;

   localparam int WPP       = (SLOTS_PER_POOL + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
   localparam int DEPTH     = POOL_COUNT * WPP;
   localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int WW        = (WPP > 1) ? $clog2(WPP) : 1;
   localparam int BW        = $clog2(MAP_WORD_BITS);
   localparam int SLOT_W    = $clog2(SLOTS_PER_POOL);
   localparam int RCP_W     = SLOT_W + 1;
   localparam int PROD_W    = SLOT_W + RCP_W;
   localparam int RECIP     = (2 ** SLOT_W) / MAP_WORD_BITS;
   localparam int LAST_BITS = SLOTS_PER_POOL - (WPP - 1) * MAP_WORD_BITS;
   localparam int SL_W      = CLS_W + 1;
   localparam logic [MAP_WORD_BITS-1:0] LAST_MASK =
      {MAP_WORD_BITS{1'b1}} >> (MAP_WORD_BITS - LAST_BITS);

   back_state_type          state_ff, state_in;
   cmd_type                 cmd_ff, cmd_in;
   logic [AW-1:0]           pool_off_ff, pool_off_in;
   logic [WW-1:0]           rd_idx_ff, rd_idx_in;
   logic [WW-1:0]           widx_ff, widx_in;
   logic [BW-1:0]           bit_ff, bit_in;
   logic [MAP_WORD_BITS-1:0] word_ff, word_in;
   logic [SLOT_W-1:0]       slot_ff, slot_in;
   logic [PROD_W-1:0]       prod_ff, prod_in;
   logic [WW-1:0]           q_ff, q_in;
   logic [SLOT_W-1:0]       qm_ff, qm_in;
   logic [ADDR_W-1:0]       addr_ff, addr_in;
   status_type              res_status_ff, res_status_in;
   logic [SLOT_W-1:0]       res_slot_ff, res_slot_in;
   logic [AW-1:0]           clr_addr_ff, clr_addr_in;
   logic [WW-1:0]           clr_word_ff, clr_word_in;

   logic                    rsp_valid_ff, rsp_valid_in;
   logic [ADDR_W-1:0]       rsp_addr_ff, rsp_addr_in;
   status_type              rsp_status_ff, rsp_status_in;
   logic [POOL_IDX_W-1:0]   rsp_pool_ff, rsp_pool_in;
   logic [SLOT_IDX_W-1:0]   rsp_slot_ff, rsp_slot_in;

   logic                    ram_we;
   logic [AW-1:0]           ram_waddr;
   logic [MAP_WORD_BITS-1:0] ram_wdata;
   logic [AW-1:0]           ram_raddr;
   logic [MAP_WORD_BITS-1:0] ram_rdata;

   logic [SL_W-1:0]         slot_log2;
   logic [ADDR_W-1:0]       free_shift;
   logic                    free_oor;
   logic                    word_hit;
   logic                    last_word;
   logic [BW-1:0]           low_bit;
   logic [RCP_W-1:0]        q_est;
   logic [SLOT_W-1:0]       rem;
   logic [WW-1:0]           widx_calc;
   logic [ADDR_W-1:0]       align_m1;
   logic [31:0]             slot_ext;
   logic                    out_free;

   function automatic logic [BW-1:0] low_set(input logic [MAP_WORD_BITS-1:0] w);
      logic [BW-1:0] p;
      p = '0;
      for (int i = MAP_WORD_BITS - 1; i >= 0; i--) begin
         if (w[i]) begin
            p = BW'(i);
         end
      end
      return p;
   endfunction

   scbpa_ram #(
      .WIDTH (MAP_WORD_BITS),
      .DEPTH (DEPTH)
   ) u_free_map (
      .clock (clock),
      .we    (ram_we),
      .waddr (ram_waddr),
      .wdata (ram_wdata),
      .raddr (ram_raddr),
      .rdata (ram_rdata)
   );

   assign slot_log2  = SL_W'(cmd_ff.cls) + SL_W'(MIN_SLOT_LOG2);
   assign free_shift = cmd_ff.diff >> slot_log2;
   assign free_oor   = cmd_ff.borrow || (free_shift >= ADDR_W'(SLOTS_PER_POOL));
   assign word_hit   = (ram_rdata != '0);
   assign last_word  = (rd_idx_ff == WW'(WPP - 1));
   assign low_bit    = low_set(ram_rdata);
   assign q_est      = prod_ff[PROD_W-1:SLOT_W];
   assign rem        = slot_ff - qm_ff;
   assign align_m1   = (ADDR_W'(1) << cmd_ff.align_log2) - ADDR_W'(1);
   assign slot_ext   = 32'(res_slot_ff);
   assign out_free   = !rsp_valid_ff || rsp.ready;
   assign clearing   = (state_ff == B_CLEAR);

   // one-step correction of the reciprocal quotient estimate
   always_comb begin
      if (32'(rem) >= MAP_WORD_BITS) begin
         widx_calc = q_ff + 1'b1;
      end else begin
         widx_calc = q_ff;
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_CLEAR: begin
            if (clr_addr_ff == AW'(DEPTH - 1)) begin
               state_in = B_IDLE;
            end
         end
         B_IDLE: begin
            if (pop_valid) begin
               state_in = B_DECODE;
            end
         end
         B_DECODE: begin
            if (cmd_ff.too_large) begin
               state_in = B_EMIT;
            end else if (cmd_ff.func == FUNC_ALLOC) begin
               state_in = B_SCAN;
            end else if (free_oor) begin
               state_in = B_EMIT;
            end else begin
               state_in = B_DIV_MUL;
            end
         end
         B_SCAN: begin
            if (word_hit) begin
               state_in = B_ALLOC_WR;
            end else if (last_word) begin
               state_in = B_EMIT;
            end
         end
         B_ALLOC_WR: state_in = B_ADDR;
         B_ADDR:     state_in = B_ALIGN;
         B_ALIGN:    state_in = B_EMIT;
         B_DIV_MUL:  state_in = B_DIV_QUO;
         B_DIV_QUO:  state_in = B_DIV_REM;
         B_DIV_REM:  state_in = B_FREE_WR;
         B_FREE_WR:  state_in = B_EMIT;
         B_EMIT: begin
            if (out_free) begin
               state_in = B_IDLE;
            end
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_comb begin
      cmd_in        = cmd_ff;
      pool_off_in   = pool_off_ff;
      rd_idx_in     = rd_idx_ff;
      widx_in       = widx_ff;
      bit_in        = bit_ff;
      word_in       = word_ff;
      slot_in       = slot_ff;
      prod_in       = prod_ff;
      q_in          = q_ff;
      qm_in         = qm_ff;
      addr_in       = addr_ff;
      res_status_in = res_status_ff;
      res_slot_in   = res_slot_ff;
      clr_addr_in   = clr_addr_ff;
      clr_word_in   = clr_word_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp.ready;
      rsp_addr_in   = rsp_addr_ff;
      rsp_status_in = rsp_status_ff;
      rsp_pool_in   = rsp_pool_ff;
      rsp_slot_in   = rsp_slot_ff;
      pop_ready     = 1'b0;
      ram_we        = 1'b0;
      ram_waddr     = clr_addr_ff;
      ram_wdata     = '0;
      ram_raddr     = pool_off_ff;
      case (state_ff)
         B_CLEAR: begin
            // every slot starts free, the tail of a pool's last word stays empty
            ram_we      = 1'b1;
            ram_wdata   = (clr_word_ff == WW'(WPP - 1)) ? LAST_MASK : '1;
            clr_addr_in = clr_addr_ff + 1'b1;
            clr_word_in = (clr_word_ff == WW'(WPP - 1)) ? '0 : clr_word_ff + 1'b1;
         end
         B_IDLE: begin
            pop_ready   = 1'b1;
            cmd_in      = pop_data;
            pool_off_in = AW'(32'(pop_data.cls) * WPP);
         end
         B_DECODE: begin
            rd_idx_in     = '0;
            addr_in       = '0;
            res_slot_in   = '0;
            res_status_in = STAT_OK;
            if (cmd_ff.too_large) begin
               res_status_in = STAT_TOO_LARGE;
            end else if (cmd_ff.func == FUNC_FREE) begin
               if (free_oor) begin
                  res_status_in = STAT_OUT_OF_POOL;
               end else begin
                  slot_in = free_shift[SLOT_W-1:0];
               end
            end
         end
         B_SCAN: begin
            // check the word read last cycle while the next read goes out
            if (word_hit) begin
               word_in = ram_rdata & ~(MAP_WORD_BITS'(1) << low_bit);
               widx_in = rd_idx_ff;
               bit_in  = low_bit;
            end else if (last_word) begin
               res_status_in = STAT_EXHAUSTED;
            end else begin
               ram_raddr = pool_off_ff + AW'(rd_idx_ff + 1'b1);
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
         B_ALLOC_WR: begin
            ram_we    = 1'b1;
            ram_waddr = pool_off_ff + AW'(widx_ff);
            ram_wdata = word_ff;
            slot_in   = SLOT_W'(32'(widx_ff) * MAP_WORD_BITS + 32'(bit_ff));
         end
         B_ADDR: begin
            addr_in       = cmd_ff.base + (ADDR_W'(slot_ff) << slot_log2);
            res_slot_in   = slot_ff;
            res_status_in = STAT_OK;
         end
         B_ALIGN: begin
            addr_in = (addr_ff + align_m1) & ~align_m1;
         end
         B_DIV_MUL: begin
            prod_in = PROD_W'(slot_ff) * PROD_W'(RECIP);
         end
         B_DIV_QUO: begin
            q_in  = WW'(q_est);
            qm_in = SLOT_W'(32'(q_est) * MAP_WORD_BITS);
         end
         B_DIV_REM: begin
            widx_in   = widx_calc;
            bit_in    = (32'(rem) >= MAP_WORD_BITS) ? BW'(32'(rem) - MAP_WORD_BITS) : BW'(rem);
            ram_raddr = pool_off_ff + AW'(widx_calc);
         end
         B_FREE_WR: begin
            ram_we        = 1'b1;
            ram_waddr     = pool_off_ff + AW'(widx_ff);
            ram_wdata     = ram_rdata | (MAP_WORD_BITS'(1) << bit_ff);
            res_slot_in   = slot_ff;
            res_status_in = STAT_OK;
         end
         B_EMIT: begin
            if (out_free) begin
               rsp_valid_in  = 1'b1;
               rsp_addr_in   = addr_ff;
               rsp_status_in = res_status_ff;
               rsp_pool_in   = cmd_ff.too_large ? '0 : cmd_ff.cls[POOL_IDX_W-1:0];
               rsp_slot_in   = slot_ext[SLOT_IDX_W-1:0];
            end
         end
         default: begin
            pop_ready = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_CLEAR;
         clr_addr_ff  <= '0;
         clr_word_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_addr_ff  <= clr_addr_in;
         clr_word_ff  <= clr_word_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      cmd_ff        <= cmd_in;
      pool_off_ff   <= pool_off_in;
      rd_idx_ff     <= rd_idx_in;
      widx_ff       <= widx_in;
      bit_ff        <= bit_in;
      word_ff       <= word_in;
      slot_ff       <= slot_in;
      prod_ff       <= prod_in;
      q_ff          <= q_in;
      qm_ff         <= qm_in;
      addr_ff       <= addr_in;
      res_status_ff <= res_status_in;
      res_slot_ff   <= res_slot_in;
      rsp_addr_ff   <= rsp_addr_in;
      rsp_status_ff <= rsp_status_in;
      rsp_pool_ff   <= rsp_pool_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign rsp.valid      = rsp_valid_ff;
   assign rsp.addr       = rsp_addr_ff;
   assign rsp.status     = rsp_status_ff;
   assign rsp.pool_index = rsp_pool_ff;
   assign rsp.slot_index = rsp_slot_ff;
endmodule

/* sv/size_class_bitmap_pool_allocator.sv */
// Segregated-fit pool allocator: POOL_COUNT pools of SLOTS_PER_POOL slots, pool c holding
// 2^(c+3)-byte slots, each tracked by a free bitmap of MAP_WORD_BITS-bit words in one RAM.
// After reset a clearing pass marks every slot free, one bitmap word per cycle, during
// which no request beat is taken; base register writes are taken at any time. Requests are
// classified on entry and wait in a two-entry queue, so the request side keeps moving while
// a result waits on the response side, until the queue is full. An allocate reads bitmap
// words one per cycle through the RAM read port until one has a free slot or the pool is
// exhausted; a free runs a reciprocal divide, then a read-modify-write of one word; a
// rejected request goes straight to its result. One request is worked at a time.
// Pool base registers must only be written while no request is outstanding.
module size_class_bitmap_pool_allocator #(
   parameter int SLOTS_PER_POOL = 1024,
   parameter int POOL_COUNT     = 8,
   parameter int MAP_WORD_BITS  = 64
) (
   input  logic         clock,
   input  logic         reset,
   scbpa_req_if.sink    req_ch,
   scbpa_rsp_if.source  rsp_ch,
   scbpa_csr_if.sink    csr_ch
);
   import scbpa_pkg::*;

   logic    clearing;
   logic    push_valid, push_ready;
   cmd_type push_data;
   logic    pop_valid, pop_ready;
   cmd_type pop_data;

   scbpa_front #(
      .POOL_COUNT (POOL_COUNT)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req        (req_ch),
      .csr        (csr_ch),
      .clearing   (clearing),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data)
   );

   scbpa_cmd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_data  (push_data),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_data   (pop_data)
   );

   scbpa_back #(
      .SLOTS_PER_POOL (SLOTS_PER_POOL),
      .POOL_COUNT     (POOL_COUNT),
      .MAP_WORD_BITS  (MAP_WORD_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_data  (pop_data),
      .clearing  (clearing),
      .rsp       (rsp_ch)
   );
endmodule

/* sv/scbpa_checker.sv */
// scbpa_checker: port-level assertions for the pool allocator, bound to the top level
// depends on scbpa_pkg and size_class_bitmap_pool_allocator
module scbpa_checker (
   input logic                              clock,
   input logic                              reset,
   input logic                              req_ready,
   input logic                              rsp_valid,
   input logic                              rsp_ready,
   input logic [scbpa_pkg::ADDR_W-1:0]      rsp_addr,
   input logic [scbpa_pkg::STATUS_W-1:0]    rsp_status,
   input logic [scbpa_pkg::POOL_IDX_W-1:0]  rsp_pool_index,
   input logic [scbpa_pkg::SLOT_IDX_W-1:0]  rsp_slot_index
);
   import scbpa_pkg::*;

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   a_rsp_stable: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_addr) && $stable(rsp_status)
         && $stable(rsp_pool_index) && $stable(rsp_slot_index))
      else $error("response payload changed while stalled");

   // the bitmap clearing pass holds off requests right after reset
   a_clear_first: assert property (@(posedge clock)
      $fell(reset) |-> !req_ready)
      else $error("request taken before bitmap clear");

   a_too_large_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == STAT_TOO_LARGE) |->
         (rsp_addr == '0) && (rsp_pool_index == '0) && (rsp_slot_index == '0))
      else $error("oversize result carries nonzero fields");

   a_fail_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == STAT_EXHAUSTED) || (rsp_status == STAT_OUT_OF_POOL)) |->
         (rsp_addr == '0) && (rsp_slot_index == '0))
      else $error("failed result carries address or slot");
endmodule

bind size_class_bitmap_pool_allocator scbpa_checker u_scbpa_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_ch.ready),
   .rsp_valid      (rsp_ch.valid),
   .rsp_ready      (rsp_ch.ready),
   .rsp_addr       (rsp_ch.addr),
   .rsp_status     (rsp_ch.status),
   .rsp_pool_index (rsp_ch.pool_index),
   .rsp_slot_index (rsp_ch.slot_index)
);

/* test/tb_size_class_bitmap_pool_allocator.sv */
`timescale 1ns / 1ps
// tb_size_class_bitmap_pool_allocator: self-checking bench for the size-class pool allocator
// depends on scbpa_pkg, the channel interfaces in scbpa_ifs and the allocator top level
module tb_size_class_bitmap_pool_allocator;
   import scbpa_pkg::*;

   localparam int POOLS = 8;
   localparam int SLOTS = 1024;
   localparam int WORD_BITS = 64;
   localparam int WORDS = SLOTS / WORD_BITS;
   localparam int POOL_BASE_REG0 = 0;
   localparam int IDLE_PERCENT = 8;
   localparam int HOLD_CYCLES = 400;
   localparam int TAIL_CYCLES = 40;
   localparam logic [ADDR_W-1:0] FIRST_BASES [POOLS] = '{
      48'h0000_0000_0000, 48'h0000_0001_0000, 48'h0000_0002_0005, 48'h0000_0040_0003,
      48'h0123_4567_8901, 48'h7FFF_FFFF_0000, 48'h8000_0000_0011, 48'hFFFF_FFFF_F800
   };

   typedef struct packed {
      func_type          func;
      logic [SIZE_W-1:0] size;
      logic [ALOG_W-1:0] align_log2;
      logic [ADDR_W-1:0] free_addr;
   } request_type;

   typedef struct packed {
      logic [ADDR_W-1:0]     addr;
      status_type            status;
      logic [POOL_IDX_W-1:0] pool_index;
      logic [SLOT_IDX_W-1:0] slot_index;
   } reply_type;

   logic clock;
   logic reset;

   scbpa_req_if req_if ();
   scbpa_rsp_if rsp_if ();
   scbpa_csr_if csr_if ();

   size_class_bitmap_pool_allocator #(
      .SLOTS_PER_POOL(SLOTS),
      .POOL_COUNT(POOLS),
      .MAP_WORD_BITS(WORD_BITS)
   ) uut (
      .clock(clock),
      .reset(reset),
      .req_ch(req_if),
      .rsp_ch(rsp_if),
      .csr_ch(csr_if)
   );

   // shadow of the allocator state
   logic [WORD_BITS-1:0] free_bits [POOLS][WORDS];
   logic [ADDR_W-1:0]    pool_base_of [POOLS];
   int                   live_grants [$];   // pool * SLOTS + slot of granted slots

   request_type pending_reqs [$];
   reply_type   awaited_replies [$];
   request_type next_req;
   request_type taken_req;
   reply_type   want;
   reply_type   predicted;
   logic        req_fired;
   bit          quiet;
   int          rsp_hold_left;

   int error_count;
   int replies_seen;
   int grants, releases, exhausted, oversize, strays;
   int base_settings;

   initial clock = 1'b0;
   always #5 clock = ~clock;

   function automatic bit takes_a_break();
      return !quiet && ($urandom_range(99) < IDLE_PERCENT);
   endfunction

   function automatic int size_class_of(logic [SIZE_W-1:0] size);
      int lg;
      lg = 0;
      for (int b = 0; b < SIZE_W; b++)
         if (size[b]) lg = b;
      if (lg < MIN_SLOT_LOG2) lg = MIN_SLOT_LOG2;
      return lg - MIN_SLOT_LOG2;
   endfunction

   // expected reply for one request; updates the shadow bitmap
   function automatic reply_type grant_or_release(request_type rq);
      reply_type         r;
      int                cls;
      int                slot_log2;
      int                low;
      int                slot;
      logic [ADDR_W-1:0] a;
      logic [ADDR_W-1:0] round_mask;
      logic [ADDR_W-1:0] offs;
      r = '0;
      r.status = STAT_OK;
      cls = size_class_of(rq.size);
      if (cls >= POOLS) begin
         r.status = STAT_TOO_LARGE;
         return r;
      end
      r.pool_index = POOL_IDX_W'(cls);
      slot_log2 = cls + MIN_SLOT_LOG2;
      if (rq.func == FUNC_ALLOC) begin
         for (int w = 0; w < WORDS; w++) begin
            if (free_bits[cls][w] != '0) begin
               low = 0;
               for (int b = WORD_BITS - 1; b >= 0; b--)
                  if (free_bits[cls][w][b]) low = b;
               free_bits[cls][w][low] = 1'b0;
               slot = w * WORD_BITS + low;
               a = pool_base_of[cls] + (ADDR_W'(slot) << slot_log2);
               round_mask = (ADDR_W'(1) << rq.align_log2) - ADDR_W'(1);
               a = (a + round_mask) & ~round_mask;
               r.addr = a;
               r.slot_index = SLOT_IDX_W'(slot);
               live_grants.push_back(cls * SLOTS + slot);
               return r;
            end
         end
         r.status = STAT_EXHAUSTED;
         return r;
      end
      if (rq.free_addr < pool_base_of[cls]) begin
         r.status = STAT_OUT_OF_POOL;
         return r;
      end
      offs = (rq.free_addr - pool_base_of[cls]) >> slot_log2;
      if (offs >= SLOTS) begin
         r.status = STAT_OUT_OF_POOL;
         return r;
      end
      free_bits[cls][offs / WORD_BITS][offs % WORD_BITS] = 1'b1;
      r.slot_index = SLOT_IDX_W'(offs);
      return r;
   endfunction

   function automatic request_type make_req(func_type f, int size, int alog,
                                            logic [ADDR_W-1:0] a);
      request_type rq;
      rq.func = f;
      rq.size = SIZE_W'(size);
      rq.align_log2 = ALOG_W'(alog);
      rq.free_addr = a;
      return rq;
   endfunction

   function automatic logic [ADDR_W-1:0] random_addr();
      return ADDR_W'({$urandom, $urandom} >> 16);
   endfunction

   function automatic int size_in_class(int cls);
      if (cls == 0) return $urandom_range(15);
      return $urandom_range((1 << (cls + 4)) - 1, 1 << (cls + 3));
   endfunction

   function automatic request_type alloc_req(int cls, int alog);
      return make_req(FUNC_ALLOC, size_in_class(cls), alog, random_addr());
   endfunction

   // free anywhere inside the given slot
   function automatic request_type free_req(int cls, int slot);
      int                slot_log2;
      logic [ADDR_W-1:0] a;
      slot_log2 = cls + MIN_SLOT_LOG2;
      a = pool_base_of[cls] + (ADDR_W'(slot) << slot_log2)
          + ADDR_W'($urandom_range((1 << slot_log2) - 1));
      return make_req(FUNC_FREE, size_in_class(cls), $urandom_range(12), a);
   endfunction

   function automatic request_type random_request();
      int                roll;
      int                cls;
      int                pick;
      int                code;
      logic [ADDR_W-1:0] a;
      roll = $urandom_range(99);
      cls = $urandom_range(POOLS - 1);
      if (roll < 45)
         return alloc_req(cls, ($urandom_range(3) == 0) ? $urandom_range(12)
                                                         : $urandom_range(cls + 3));
      if (roll < 85) begin
         if (live_grants.size() != 0 && $urandom_range(3) != 0) begin
            pick = $urandom_range(live_grants.size() - 1);
            code = live_grants[pick];
            live_grants.delete(pick);
            return free_req(code / SLOTS, code % SLOTS);
         end
         return free_req(cls, $urandom_range(SLOTS - 1));
      end
      if (roll < 92)
         return make_req(func_type'($urandom_range(1)), $urandom_range(65535, 2048),
                         $urandom_range(12), random_addr());
      // stray free: below the pool, just past it, or anywhere
      case ($urandom_range(2))
         0: a = pool_base_of[cls] - ADDR_W'($urandom_range(64, 1));
         1: a = pool_base_of[cls] + (ADDR_W'(SLOTS) << (cls + MIN_SLOT_LOG2))
                + ADDR_W'($urandom_range(4095));
         default: a = random_addr();
      endcase
      return make_req(FUNC_FREE, size_in_class(cls), $urandom_range(12), a);
   endfunction

   task automatic write_pool_base(input int pool, input logic [ADDR_W-1:0] value);
      @(negedge clock);
      csr_if.valid <= 1'b1;
      csr_if.index <= CSR_IDX_W'(POOL_BASE_REG0 + pool);
      csr_if.data  <= value;
      do @(posedge clock); while (!csr_if.ready);
      pool_base_of[pool] = value;
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   task automatic wait_drained();
      do @(posedge clock);
      while (pending_reqs.size() != 0 || req_if.valid || awaited_replies.size() != 0);
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   task automatic report_fault(input string msg);
      error_count++;
      if (error_count <= 10) $display("ERROR @%0t: %s", $time, msg);
   endtask

   // request driver
   always @(negedge clock) begin
      if (reset) begin
         req_if.valid <= 1'b0;
      end else if (!req_if.valid || req_fired) begin
         if (pending_reqs.size() != 0 && !takes_a_break()) begin
            next_req = pending_reqs.pop_front();
            req_if.valid      <= 1'b1;
            req_if.func       <= next_req.func;
            req_if.req_size   <= next_req.size;
            req_if.align_log2 <= next_req.align_log2;
            req_if.free_addr  <= next_req.free_addr;
         end else begin
            req_if.valid <= 1'b0;
         end
      end
   end

   // reply receiver, with a counted hold-off on request
   always @(negedge clock) begin
      if (reset) begin
         rsp_if.ready <= 1'b0;
      end else if (rsp_hold_left > 0) begin
         rsp_if.ready <= 1'b0;
         rsp_hold_left <= rsp_hold_left - 1;
      end else begin
         rsp_if.ready <= !takes_a_break();
      end
   end

   // monitor: check reply beats, predict on request beats
   always @(posedge clock) begin
      req_fired <= !reset && req_if.valid && req_if.ready;
      if (!reset && rsp_if.valid && rsp_if.ready) begin
         if (awaited_replies.size() == 0) begin
            report_fault($sformatf("unexpected reply addr=%h status=%0d pool=%0d slot=%0d",
                                   rsp_if.addr, rsp_if.status, rsp_if.pool_index,
                                   rsp_if.slot_index));
         end else begin
            want = awaited_replies.pop_front();
            if (rsp_if.addr !== want.addr || rsp_if.status !== want.status ||
                rsp_if.pool_index !== want.pool_index ||
                rsp_if.slot_index !== want.slot_index)
               report_fault($sformatf({"reply %0d: expected addr=%h status=%0d pool=%0d ",
                                       "slot=%0d, got addr=%h status=%0d pool=%0d slot=%0d"},
                                      replies_seen, want.addr, want.status, want.pool_index,
                                      want.slot_index, rsp_if.addr, rsp_if.status,
                                      rsp_if.pool_index, rsp_if.slot_index));
            case (want.status)
               STAT_EXHAUSTED: exhausted++;
               STAT_TOO_LARGE: oversize++;
               STAT_OUT_OF_POOL: strays++;
               default: ;
            endcase
         end
         replies_seen++;
      end
      if (!reset && req_if.valid && req_if.ready) begin
         taken_req.func       = func_type'(req_if.func);
         taken_req.size       = req_if.req_size;
         taken_req.align_log2 = req_if.align_log2;
         taken_req.free_addr  = req_if.free_addr;
         predicted = grant_or_release(taken_req);
         if (predicted.status == STAT_OK) begin
            if (taken_req.func == FUNC_ALLOC) grants++;
            else releases++;
         end
         awaited_replies.push_back(predicted);
      end
   end

   initial begin
      #5_000_000;
      $display("timeout: %0d replies still awaited", awaited_replies.size());
      $display("== FAIL ==");
      $finish;
   end

   initial begin : stimulus
      int fill_cls;
      reset = 1'b1;
      quiet = 1'b0;
      rsp_hold_left = 0;
      error_count = 0;
      replies_seen = 0;
      grants = 0;
      releases = 0;
      exhausted = 0;
      oversize = 0;
      strays = 0;
      base_settings = 0;
      csr_if.valid = 1'b0;
      csr_if.index = '0;
      csr_if.data = '0;
      req_if.valid = 1'b0;
      req_if.func = 1'b0;
      req_if.req_size = '0;
      req_if.align_log2 = '0;
      req_if.free_addr = '0;
      rsp_if.ready = 1'b0;
      for (int p = 0; p < POOLS; p++) begin
         pool_base_of[p] = '0;
         for (int w = 0; w < WORDS; w++) free_bits[p][w] = '1;
      end
      repeat (10) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed: field extremes, class edges, alignment, the rejection cases
      for (int p = 0; p < POOLS; p++) write_pool_base(p, FIRST_BASES[p]);
      base_settings++;
      pending_reqs.push_back(make_req(FUNC_ALLOC, 0, 0, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 15, 12, '1));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 8, 3, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 16, 0, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 2047, 0, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 1024, 12, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 2048, 0, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 65535, 12, '1));
      pending_reqs.push_back(make_req(FUNC_FREE, 65535, 0, '1));
      pending_reqs.push_back(make_req(FUNC_FREE, 0, 0, pool_base_of[0] + 8));
      pending_reqs.push_back(make_req(FUNC_FREE, 7, 0, pool_base_of[0] + 8));
      pending_reqs.push_back(make_req(FUNC_FREE, 16, 0, pool_base_of[1] - 1));
      pending_reqs.push_back(make_req(FUNC_FREE, 16, 0, pool_base_of[1] + SLOTS * 16));
      pending_reqs.push_back(make_req(FUNC_FREE, 31, 0,
                                      pool_base_of[1] + (SLOTS - 1) * 16 + 15));
      pending_reqs.push_back(make_req(FUNC_FREE, 32, 0, '1));
      pending_reqs.push_back(make_req(FUNC_FREE, 0, 0, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 0, 0, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 100, 5, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 512, 9, '0));
      pending_reqs.push_back(make_req(FUNC_FREE, 1500, 0, pool_base_of[7]));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 1500, 10, '0));
      pending_reqs.push_back(make_req(FUNC_ALLOC, 7, 0, '0));
      pending_reqs.push_back(make_req(FUNC_FREE, 8, 0, pool_base_of[0] + 8 * 1023 + 7));
      wait_drained();

      // random bases, first half without any idling
      for (int p = 0; p < POOLS; p++) write_pool_base(p, random_addr());
      base_settings++;
      quiet = 1'b1;
      for (int i = 0; i < 100; i++) pending_reqs.push_back(random_request());
      wait_drained();
      quiet = 1'b0;
      for (int i = 0; i < 100; i++) pending_reqs.push_back(random_request());
      wait_drained();

      // long reply stall while requests keep coming
      rsp_hold_left = HOLD_CYCLES;
      for (int i = 0; i < 40; i++) pending_reqs.push_back(random_request());
      wait_drained();

      // zero bases; run one pool dry, then free and reuse its slots
      for (int p = 0; p < POOLS; p++) write_pool_base(p, '0);
      base_settings++;
      fill_cls = $urandom_range(POOLS - 1);
      for (int i = 0; i < 1060; i++) begin
         if (i % 40 == 20)
            pending_reqs.push_back(free_req(fill_cls, $urandom_range(SLOTS - 1)));
         else
            pending_reqs.push_back(alloc_req(fill_cls, $urandom_range(fill_cls + 3)));
      end
      wait_drained();
      for (int i = 0; i < 40; i++) pending_reqs.push_back(random_request());
      wait_drained();

      // all-ones bases: any nonzero offset wraps the address sum
      for (int p = 0; p < POOLS; p++) write_pool_base(p, '1);
      base_settings++;
      for (int i = 0; i < 100; i++) pending_reqs.push_back(random_request());
      wait_drained();

      $display("checked %0d replies over %0d base settings", replies_seen, base_settings);
      $display("grants %0d, releases %0d, exhausted %0d, oversize %0d, out of pool %0d",
               grants, releases, exhausted, oversize, strays);
      if (error_count == 0) begin
         $display("== PASS ==");
      end else begin
         $display("%0d mismatches", error_count);
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule

/* sim.f */
sv/scbpa_pkg.sv
sv/scbpa_ifs.sv
sv/scbpa_ram.sv
sv/scbpa_front.sv
sv/scbpa_cmd_queue.sv
sv/scbpa_back.sv
sv/size_class_bitmap_pool_allocator.sv
sv/scbpa_checker.sv
test/tb_size_class_bitmap_pool_allocator.sv
